FILE: rtl/bwm_pkg.sv
// shared types and constants for the breakpoint and watchpoint match unit
package bwm_pkg;

   localparam int SLOTS = 16;
   localparam int SLOT_W = $clog2(SLOTS);

   localparam logic [7:0] NO_HIT = 8'hff;

   localparam int FL_EXEC = 0;
   localparam int FL_LOAD = 1;
   localparam int FL_STORE = 2;
   localparam int FL_PAUSE = 3;
   localparam int FL_DEV = 4;

   typedef enum logic [2:0] {
      KIND_HOOK = 3'd0,
      KIND_SET = 3'd1,
      KIND_DEV = 3'd2,
      KIND_PAUSE = 3'd3,
      KIND_RESUME = 3'd4,
      KIND_STEP_IN = 3'd5,
      KIND_STEP_OVER = 3'd6,
      KIND_STEP_OUT = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      MODE_EXEC = 2'd0,
      MODE_PAUSE = 2'd1,
      MODE_OVER = 2'd2,
      MODE_OUT = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      CLS_OTHER = 3'd0,
      CLS_MEM_LOAD = 3'd1,
      CLS_MEM_STORE = 3'd2,
      CLS_DEV_LOAD = 3'd3,
      CLS_DEV_STORE = 3'd4
   } cls_type;

   localparam logic [4:0] OP_LDZ = 5'h10;
   localparam logic [4:0] OP_STZ = 5'h11;
   localparam logic [4:0] OP_LDR = 5'h12;
   localparam logic [4:0] OP_STR = 5'h13;
   localparam logic [4:0] OP_LDA = 5'h14;
   localparam logic [4:0] OP_STA = 5'h15;
   localparam logic [4:0] OP_DEI = 5'h16;
   localparam logic [4:0] OP_DEO = 5'h17;
   localparam logic [7:0] OP_BRK = 8'h00;

   typedef struct packed {
      logic [2:0] kind;
      logic [15:0] pc;
      logic [7:0] opcode;
      logic [7:0] wst_top;
      logic [7:0] wst_next;
      logic [7:0] rst_top;
      logic [7:0] rst_next;
      logic [7:0] ret_depth;
      logic [7:0] entry_index;
      logic [15:0] target_addr;
      logic [7:0] entry_flags;
      logic [7:0] device_value;
   } req_type;

   typedef struct packed {
      logic hit_found;
      logic [7:0] hit_index;
      logic pause_now;
      logic exec_begin;
      logic exec_end;
      logic [7:0] active_entries;
   } rsp_type;

endpackage

FILE: rtl/breakpoint_watchpoint_match_unit.sv
// breakpoint and watchpoint match unit for a stack machine debugger
//
// one command channel: req_data is taken at a clock edge where start is high
// and busy is low; busy falls in the cycle the word's result is on the ports.
// each result is on rsp_data for one cycle, marked by rsp_valid; the receiver
// cannot stall it.
// a hook word scans the slot table: slot address and flags live in
// synchronous memories with one read port, the device page in one with two
// read ports. each slot scanned takes an address issue and a compare step,
// and device slots a further read and compare for the vector pair. the scan
// stops at the first hit, at the end of the used span, or at once when no
// slot has flags set. set entry writes an in-range slot and recounts the used
// span and the flag union over the whole table. device writes and mode
// commands go straight to the result step, where the device write is made.
// after reset a clearing pass zeroes the device page and the slot table;
// busy is high during it.
module breakpoint_watchpoint_match_unit
   import bwm_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input req_type req_data,
   output logic rsp_valid,
   output rsp_type rsp_data
);

   typedef enum logic [8:0] {
      ST_CLEAR = 9'b000000001,
      ST_IDLE = 9'b000000010,
      ST_SCAN_RD = 9'b000000100,
      ST_SCAN_CMP = 9'b000001000,
      ST_VEC_RD = 9'b000010000,
      ST_VEC_CMP = 9'b000100000,
      ST_SET_RD = 9'b001000000,
      ST_SET_ACC = 9'b010000000,
      ST_DONE = 9'b100000000
   } state_type;

   // memories
   logic [15:0] addr_mem [SLOTS];
   logic [7:0] flag_mem [SLOTS];
   logic [7:0] dev_mem [256];
   logic [15:0] addr_rd;
   logic [7:0] flag_rd;
   logic [7:0] dev_rd0;
   logic [7:0] dev_rd1;

   state_type state_ff, state_in;
   req_type req_ff;
   logic [8:0] cnt_ff, cnt_in;
   logic [7:0] used_ff, used_in;
   logic [7:0] union_ff, union_in;
   logic running_ff, running_in;
   mode_type mode_ff, mode_in;
   logic [7:0] saved_ff, saved_in;
   logic begin_ff, begin_in;
   logic [7:0] hit_ff, hit_in;
   logic [7:0] acc_ff, acc_in;
   logic [7:0] last_ff, last_in;
   logic [7:0] fl_ff, fl_in;
   logic [15:0] ad_ff, ad_in;
   logic rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   logic [SLOT_W-1:0] rd_idx;
   logic [7:0] dev_a0, dev_a1;
   logic slot_we;
   logic [SLOT_W-1:0] slot_wa;
   logic [15:0] slot_wd_addr;
   logic [7:0] slot_wd_flags;
   logic dev_we;
   logic [7:0] dev_wa;
   logic [7:0] dev_wd;

   // decode of the hook word
   cls_type cls;
   logic [15:0] a1, a2;
   logic [7:0] top, nxt;
   logic [7:0] scan_n;
   logic on_hit;
   logic acc_dev;
   logic [15:0] vec;
   logic mode_pause;
   logic [7:0] set_fl;

   always_comb begin
      top = req_ff.opcode[6] ? req_ff.rst_top : req_ff.wst_top;
      nxt = req_ff.opcode[6] ? req_ff.rst_next : req_ff.wst_next;
      cls = CLS_OTHER;
      a1 = '0;
      unique case (req_ff.opcode[4:0])
         OP_DEI: begin cls = CLS_DEV_LOAD; a1 = {8'h00, top}; end
         OP_DEO: begin cls = CLS_DEV_STORE; a1 = {8'h00, top}; end
         OP_LDZ: begin cls = CLS_MEM_LOAD; a1 = {8'h00, top}; end
         OP_STZ: begin cls = CLS_MEM_STORE; a1 = {8'h00, top}; end
         OP_LDR: begin cls = CLS_MEM_LOAD; a1 = req_ff.pc + 16'd1 + {{8{top[7]}}, top}; end
         OP_STR: begin cls = CLS_MEM_STORE; a1 = req_ff.pc + 16'd1 + {{8{top[7]}}, top}; end
         OP_LDA: begin cls = CLS_MEM_LOAD; a1 = {nxt, top}; end
         OP_STA: begin cls = CLS_MEM_STORE; a1 = {nxt, top}; end
         default: begin cls = CLS_OTHER; a1 = '0; end
      endcase
      a2 = a1 + {15'd0, req_ff.opcode[5]};
      scan_n = (used_ff > 8'(SLOTS)) ? 8'(SLOTS) : used_ff;
      on_hit = (a1 == ad_ff) || (a2 == ad_ff);
      acc_dev = on_hit && ((fl_ff[FL_LOAD] && cls == CLS_DEV_LOAD) ||
                           (fl_ff[FL_STORE] && cls == CLS_DEV_STORE));
      vec = {dev_rd0, dev_rd1};
      // the slot being set uses the new flags from the request; slot 0 is read in the same cycle it is written
      set_fl = (cnt_ff[SLOT_W-1:0] == req_ff.entry_index[SLOT_W-1:0]) ?
               req_ff.entry_flags : flag_rd;
      unique case (mode_ff)
         MODE_PAUSE: mode_pause = 1'b1;
         MODE_OVER: mode_pause = req_ff.ret_depth == saved_ff;
         MODE_OUT: mode_pause = req_ff.ret_depth < saved_ff;
         default: mode_pause = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         addr_mem[slot_wa] <= slot_wd_addr;
         flag_mem[slot_wa] <= slot_wd_flags;
      end
      addr_rd <= addr_mem[rd_idx];
      flag_rd <= flag_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (dev_we) begin
         dev_mem[dev_wa] <= dev_wd;
      end
      dev_rd0 <= dev_mem[dev_a0];
      dev_rd1 <= dev_mem[dev_a1];
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      used_in = used_ff;
      union_in = union_ff;
      running_in = running_ff;
      mode_in = mode_ff;
      saved_in = saved_ff;
      begin_in = begin_ff;
      hit_in = hit_ff;
      acc_in = acc_ff;
      last_in = last_ff;
      fl_in = fl_ff;
      ad_in = ad_ff;
      rsp_in = rsp_ff;
      rd_idx = cnt_ff[SLOT_W-1:0];
      dev_a0 = ad_ff[7:0];
      dev_a1 = ad_ff[7:0] + 8'd1;
      slot_we = 1'b0;
      slot_wa = req_ff.entry_index[SLOT_W-1:0];
      slot_wd_addr = req_ff.target_addr;
      slot_wd_flags = req_ff.entry_flags;
      dev_we = 1'b0;
      dev_wa = req_ff.target_addr[7:0];
      dev_wd = req_ff.device_value;

      unique case (state_ff)
         ST_CLEAR: begin
            dev_we = 1'b1;
            dev_wa = cnt_ff[7:0];
            dev_wd = '0;
            slot_we = cnt_ff < 9'(SLOTS);
            slot_wa = cnt_ff[SLOT_W-1:0];
            slot_wd_addr = '0;
            slot_wd_flags = '0;
            cnt_in = cnt_ff + 9'd1;
            if (cnt_ff == 9'd255) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cnt_in = '0;
         end
         ST_SCAN_RD: begin
            // memory read for slot cnt issued here
            if (cnt_ff[7:0] >= scan_n || union_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SCAN_CMP;
            end
         end
         ST_SCAN_CMP: begin
            fl_in = flag_rd;
            ad_in = addr_rd;
            if (flag_rd == '0) begin
               cnt_in = cnt_ff + 9'd1;
               state_in = ST_SCAN_RD;
            end else if (flag_rd[FL_DEV]) begin
               state_in = ST_VEC_RD;
            end else if ((flag_rd[FL_EXEC] && addr_rd == req_ff.pc) ||
                         (((flag_rd[FL_LOAD] && cls == CLS_MEM_LOAD) ||
                           (flag_rd[FL_STORE] && cls == CLS_MEM_STORE)) &&
                          (a1 == addr_rd || a2 == addr_rd))) begin
               hit_in = cnt_ff[7:0];
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 9'd1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_VEC_RD: begin
            state_in = ST_VEC_CMP;
         end
         ST_VEC_CMP: begin
            if ((fl_ff[FL_EXEC] && begin_ff && vec == req_ff.pc) || acc_dev) begin
               hit_in = cnt_ff[7:0];
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 9'd1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_SET_RD: begin
            // the new entry goes in on the first pass
            slot_we = cnt_ff == '0;
            state_in = ST_SET_ACC;
         end
         ST_SET_ACC: begin
            // slots above the used span are always zero, so the whole table
            // gives the new span and union
            if (set_fl != '0) begin
               last_in = cnt_ff[7:0] + 8'd1;
               acc_in = acc_ff | set_fl;
            end
            if (cnt_ff == 9'(SLOTS - 1)) begin
               used_in = (set_fl != '0) ? 8'(SLOTS) : last_ff;
               union_in = acc_ff | set_fl;
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 9'd1;
               state_in = ST_SET_RD;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
            dev_we = kind_type'(req_ff.kind) == KIND_DEV;
            rsp_in.hit_found = 1'b0;
            rsp_in.hit_index = NO_HIT;
            rsp_in.pause_now = 1'b0;
            rsp_in.exec_begin = 1'b0;
            rsp_in.exec_end = 1'b0;
            rsp_in.active_entries = used_ff;
            if (kind_type'(req_ff.kind) == KIND_HOOK) begin
               rsp_in.hit_found = hit_ff != NO_HIT;
               rsp_in.hit_index = hit_ff;
               rsp_in.pause_now = (hit_ff != NO_HIT && fl_ff[FL_PAUSE]) || mode_pause;
               rsp_in.exec_begin = begin_ff;
               rsp_in.exec_end = req_ff.opcode == OP_BRK;
               if (req_ff.opcode == OP_BRK) begin
                  running_in = 1'b0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (state_ff == ST_IDLE && start) begin
         cnt_in = '0;
         hit_in = NO_HIT;
         acc_in = '0;
         last_in = '0;
         fl_in = '0;
         unique case (kind_type'(req_data.kind))
            KIND_HOOK: begin
               begin_in = !running_ff;
               running_in = 1'b1;
               state_in = ST_SCAN_RD;
            end
            KIND_SET: begin
               state_in = (req_data.entry_index < 8'(SLOTS)) ? ST_SET_RD : ST_DONE;
            end
            KIND_DEV: state_in = ST_DONE;
            KIND_PAUSE, KIND_STEP_IN: begin
               mode_in = MODE_PAUSE;
               state_in = ST_DONE;
            end
            KIND_RESUME: begin
               mode_in = MODE_EXEC;
               state_in = ST_DONE;
            end
            KIND_STEP_OVER: begin
               mode_in = MODE_OVER;
               saved_in = req_data.ret_depth;
               state_in = ST_DONE;
            end
            default: begin
               if (req_data.ret_depth != '0) begin
                  mode_in = MODE_OUT;
                  saved_in = req_data.ret_depth;
               end else begin
                  mode_in = MODE_EXEC;
               end
               state_in = ST_DONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff <= '0;
         used_ff <= '0;
         union_ff <= '0;
         running_ff <= 1'b0;
         mode_ff <= MODE_EXEC;
         saved_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         used_ff <= used_in;
         union_ff <= union_in;
         running_ff <= running_in;
         mode_ff <= mode_in;
         saved_ff <= saved_in;
         rsp_valid_ff <= state_ff == ST_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         req_ff <= req_data;
      end
      begin_ff <= begin_in;
      hit_ff <= hit_in;
      acc_ff <= acc_in;
      last_ff <= last_in;
      fl_ff <= fl_in;
      ad_ff <= ad_in;
      rsp_ff <= rsp_in;
   end

   assign busy = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

FILE: rtl/bwm_checker.sv
// port-level checks for the breakpoint and watchpoint match unit
module bwm_checker
   import bwm_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input rsp_type rsp_data
);

   a_hit_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.hit_found == (rsp_data.hit_index != NO_HIT)))
      else $error("hit flag and index disagree");

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a word in flight");

   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two results in a row");

   a_begin_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.hit_found) |-> (rsp_data.hit_index == NO_HIT))
      else $error("no hit but index set");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("word taken but busy stayed low");

endmodule

bind breakpoint_watchpoint_match_unit bwm_checker u_bwm_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_valid(rsp_valid),
   .rsp_data(rsp_data)
);
